// File: hw/rtl/bta_pkg.sv
package bta_pkg;

   localparam int REQ_W    = 4;   // width of the requester field
   localparam int ISSUED_W = 8;   // width of the reported ticket
   localparam int RSP_W    = 16;  // result tdata width, padded to whole bytes
   localparam int REQ_DW   = 8;   // request tdata width, padded to whole bytes

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAX,
      ST_WRITE,
      ST_MIN,
      ST_DONE
   } state_type;

   typedef enum logic {
      SCAN_MAX,
      SCAN_MIN
   } scan_mode_type;

   // control from the sequencer to the scan accumulator
   typedef struct packed {
      logic              clear;
      logic              sample;
      scan_mode_type     mode;
      logic [REQ_W-1:0]  idx;
   } scan_ctrl_type;

endpackage

// File: hw/rtl/bakery_ticket_arbiter.sv
// Bakery ticket arbiter: one ticket per requester, held in a small RAM.
// Request channel (req_*): req_tuser carries the command (0 acquire, 1
// release), req_tdata[3:0] the requester index. Acquire gives the requester
// the largest held ticket plus one, clamped at the top value; release clears
// it. Requesters at or above REQUESTERS change nothing.
// Result channel (rsp_*): one transfer per request with the ticket now held,
// the current holder (smallest nonzero ticket, lower index on ties) and the
// saturation flag.
// Sequence: an acquire runs one read sweep of the ticket RAM for the maximum,
// the write state, a second read sweep for the minimum, and a result load.
// A release skips the first sweep; an out-of-range request skips it and the
// write. The RAM read port is registered and reads one entry a cycle. One
// request is worked on at a time; the next transfer is taken the cycle after
// a result is loaded.
// Reset clears every per-entry valid bit, so all tickets read as zero at
// once; no clearing pass is needed. A stalled result waits in the output
// register while the next request is taken; the sweep that follows then
// holds in its last state until the result register is free.
module bakery_ticket_arbiter
   import bta_pkg::*;
#(
   parameter int REQUESTERS  = 10,
   parameter int TICKET_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // [3:0] requester, [7:4] zero
   input  logic              req_tuser,   // [0] command
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // [7:0] ticket_issued, [8] grant_valid,
                                          // [12:9] granted_requester,
                                          // [13] ticket_saturated, [15:14] zero
);

   localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REQUESTERS - 1);
   localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

   state_type state_ff, state_in;

   // ticket RAM with per-entry valid bits
   logic [TICKET_BITS-1:0] mem [REQUESTERS];
   logic [REQUESTERS-1:0]  entry_valid_ff;
   logic [TICKET_BITS-1:0] rd_data_ff;
   logic                   rd_ok_ff;
   logic                   rd_vld_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [IDX_W-1:0]       addr_ff;
   logic                   issue_done_ff;

   // request registers
   logic                   cmd_ff;
   logic [REQ_W-1:0]       req_ff;
   logic                   in_range_ff;
   logic [TICKET_BITS-1:0] issued_ff;
   logic                   sat_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff;

   // sequencer outputs
   logic                   accept;
   logic                   rd_en;
   logic                   mem_we;
   logic                   sweep_start;
   logic                   load_rsp;
   logic                   last_sample;
   scan_ctrl_type          scan_ctrl;

   logic [TICKET_BITS-1:0] scan_best;
   logic                   scan_found;
   logic [REQ_W-1:0]       scan_who;
   logic [TICKET_BITS-1:0] sample_ticket;
   logic [TICKET_BITS-1:0] write_ticket;
   logic                   write_sat;
   logic [TICKET_BITS+ISSUED_W-1:0] issued_ext;
   logic                   req_in_range;

   assign req_in_range = ({1'b0, req_tdata[REQ_W-1:0]} < (REQ_W + 1)'(REQUESTERS));
   assign accept       = req_tvalid && req_tready;
   assign last_sample  = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign sample_ticket = rd_ok_ff ? rd_data_ff : '0;

   // ticket to store in the write cycle
   always_comb begin
      write_ticket = '0;
      write_sat    = 1'b0;
      if (cmd_ff == CMD_ACQUIRE) begin
         if (scan_best == TICKET_TOP) begin
            write_ticket = TICKET_TOP;
            write_sat    = 1'b1;
         end else begin
            write_ticket = scan_best + TICKET_BITS'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_in_range) begin
                  state_in = ST_MIN;
               end else if (req_tuser == CMD_ACQUIRE) begin
                  state_in = ST_MAX;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_MAX: begin
            if (last_sample) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_MIN;
         ST_MIN: begin
            if (last_sample) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      rd_en       = 1'b0;
      mem_we      = 1'b0;
      sweep_start = 1'b0;
      load_rsp    = 1'b0;
      scan_ctrl.mode = SCAN_MIN;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            sweep_start = accept;
         end
         ST_MAX: begin
            rd_en          = !issue_done_ff;
            scan_ctrl.mode = SCAN_MAX;
         end
         ST_WRITE: begin
            mem_we      = in_range_ff;
            sweep_start = 1'b1;
         end
         ST_MIN: rd_en = !issue_done_ff;
         ST_DONE: load_rsp = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
      scan_ctrl.clear  = sweep_start;
      scan_ctrl.sample = rd_vld_ff;
      scan_ctrl.idx    = REQ_W'(rd_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // RAM: write in the write cycle, registered read during the sweeps
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_ff[IDX_W-1:0]] <= write_ticket;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_vld_ff      <= 1'b0;
         rd_ok_ff       <= 1'b0;
         addr_ff        <= '0;
         issue_done_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            entry_valid_ff[req_ff[IDX_W-1:0]] <= 1'b1;
         end
         rd_vld_ff <= rd_en;
         if (rd_en) begin
            rd_ok_ff <= entry_valid_ff[addr_ff];
         end
         if (sweep_start) begin
            addr_ff       <= '0;
            issue_done_ff <= 1'b0;
         end else if (rd_en) begin
            if (addr_ff == LAST_IDX) begin
               issue_done_ff <= 1'b1;
            end else begin
               addr_ff <= addr_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
   end

   // request capture and issued ticket
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_tuser;
         req_ff      <= req_tdata[REQ_W-1:0];
         in_range_ff <= req_in_range;
         issued_ff   <= '0;
         sat_ff      <= 1'b0;
      end else if (state_ff == ST_WRITE) begin
         issued_ff <= write_ticket;
         sat_ff    <= write_sat;
      end
   end

   bta_scan #(
      .TICKET_BITS(TICKET_BITS)
   ) u_scan (
      .clock (clock),
      .ctrl  (scan_ctrl),
      .ticket(sample_ticket),
      .best  (scan_best),
      .found (scan_found),
      .who   (scan_who)
   );

   // result register
   assign issued_ext   = {{ISSUED_W{1'b0}}, issued_ff};
   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {2'b00, sat_ff, (scan_found ? scan_who : {REQ_W{1'b0}}),
                         scan_found, issued_ext[ISSUED_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // no holder means the holder index reads zero
   a_no_holder_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[8]) |-> (rsp_tdata[12:9] == '0))
      else $error("granted_requester nonzero without a holder");

   // a reported holder is always a real requester
   a_holder_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |->
         ({1'b0, rsp_tdata[12:9]} < (REQ_W + 1)'(REQUESTERS)))
      else $error("granted_requester out of range");

   // a saturated ticket is the top value
   a_sat_is_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIN && sat_ff) |-> (issued_ff == TICKET_TOP))
      else $error("saturation flag without top ticket");

   // the RAM is written only for an in-range request
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, req_ff} < (REQ_W + 1)'(REQUESTERS)))
      else $error("ticket RAM written for out-of-range requester");
`endif

endmodule

// File: hw/rtl/bta_scan.sv
module bta_scan
   import bta_pkg::*;
#(
   parameter int TICKET_BITS = 8
) (
   input  logic                   clock,
   input  scan_ctrl_type          ctrl,
   input  logic [TICKET_BITS-1:0] ticket,
   output logic [TICKET_BITS-1:0] best,
   output logic                   found,
   output logic [REQ_W-1:0]       who
);

   logic [TICKET_BITS-1:0] best_ff, best_in;
   logic                   found_ff, found_in;
   logic [REQ_W-1:0]       who_ff, who_in;

   always_comb begin
      best_in  = best_ff;
      found_in = found_ff;
      who_in   = who_ff;
      if (ctrl.clear) begin
         best_in  = '0;
         found_in = 1'b0;
         who_in   = '0;
      end else if (ctrl.sample) begin
         case (ctrl.mode)
            SCAN_MAX: begin
               if (ticket > best_ff) begin
                  best_in = ticket;
               end
            end
            default: begin
               // strict less-than keeps the lower index on ties
               if (ticket != '0 && (!found_ff || ticket < best_ff)) begin
                  best_in  = ticket;
                  found_in = 1'b1;
                  who_in   = ctrl.idx;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      best_ff  <= best_in;
      found_ff <= found_in;
      who_ff   <= who_in;
   end

   assign best  = best_ff;
   assign found = found_ff;
   assign who   = who_ff;

endmodule
